>>> rtl/ffha_pkg.sv
// shared types and codes for the first-fit heap allocator
package ffha_pkg;

  localparam int REQ_W = 15;
  localparam int OFS_W = 14;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FREE_DONE = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [REQ_W-1:0] request_bytes;
    logic [OFS_W-1:0] data_offset;
    logic             pointer_null;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFS_W-1:0] alloc_offset;
  } res_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_ROUND,
    OP_START,
    OP_READ_CUR,
    OP_ADVANCE,
    OP_SPLIT_TAIL,
    OP_SPLIT_HEAD,
    OP_UNLINK,
    OP_CLEAR_NEXT,
    OP_LINK_BLK,
    OP_LINK_PREV,
    OP_READ_BLK,
    OP_KEEP_BLK_READ_CUR,
    OP_MERGE_NEXT,
    OP_READ_PREV,
    OP_KEEP_PREV_READ_BLK,
    OP_MERGE_PREV
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_load;
    logic [1:0] res_status;
  } dp_ctl_t;

  typedef struct packed {
    logic is_free;
    logic skip_free;
    logic cur_nil;
    logic prev_nil;
    logic steps_max;
    logic cur_below_blk;
    logic fits;
    logic split;
    logic next_adj;
    logic prev_adj;
  } dp_stat_t;

endpackage

>>> rtl/ffha_ctrl.sv
// sequencer for the allocate and free list walks
module ffha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  output logic              res_valid,
  input  logic              res_stall,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_ctl_t  ctl
);

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_ROUND,
    S_START,
    S_A_CHECK,
    S_A_EVAL,
    S_A_SPLIT,
    S_A_CLEAR,
    S_F_CHECK,
    S_F_EVAL,
    S_F_LINK_PREV,
    S_F_READ_BLK,
    S_F_NEXT_TEST,
    S_F_NEXT_MERGE,
    S_F_PREV_READ,
    S_F_PREV_KEEP,
    S_F_PREV_TEST,
    S_DONE
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_code, res_code_next;
  logic       res_take;

  assign res_take = !res_valid || !res_stall;

  always_comb begin
    state_next     = state;
    res_code_next  = res_code;
    ctl.op         = ffha_pkg::OP_NONE;
    ctl.res_load   = 1'b0;
    ctl.res_status = res_code;
    unique case (state)
      S_INIT: begin
        ctl.op     = ffha_pkg::OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.op     = ffha_pkg::OP_LOAD;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        ctl.op     = ffha_pkg::OP_ROUND;
        state_next = S_START;
      end
      S_START: begin
        ctl.op = ffha_pkg::OP_START;
        if (!stat.is_free) begin
          state_next = S_A_CHECK;
        end else if (stat.skip_free) begin
          res_code_next = ffha_pkg::ST_FREE_DONE;
          state_next    = S_DONE;
        end else begin
          state_next = S_F_CHECK;
        end
      end
      S_A_CHECK: begin
        if (stat.cur_nil || stat.steps_max) begin
          res_code_next = ffha_pkg::ST_NO_FIT;
          state_next    = S_DONE;
        end else begin
          ctl.op     = ffha_pkg::OP_READ_CUR;
          state_next = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        if (stat.fits && stat.split) begin
          ctl.op     = ffha_pkg::OP_SPLIT_TAIL;
          state_next = S_A_SPLIT;
        end else if (stat.fits) begin
          ctl.op     = ffha_pkg::OP_UNLINK;
          state_next = S_A_CLEAR;
        end else begin
          ctl.op     = ffha_pkg::OP_ADVANCE;
          state_next = S_A_CHECK;
        end
      end
      S_A_SPLIT: begin
        ctl.op     = ffha_pkg::OP_SPLIT_HEAD;
        state_next = S_A_CLEAR;
      end
      S_A_CLEAR: begin
        ctl.op        = ffha_pkg::OP_CLEAR_NEXT;
        res_code_next = ffha_pkg::ST_ALLOCATED;
        state_next    = S_DONE;
      end
      S_F_CHECK: begin
        if (!stat.cur_nil && stat.cur_below_blk && !stat.steps_max) begin
          ctl.op     = ffha_pkg::OP_READ_CUR;
          state_next = S_F_EVAL;
        end else begin
          ctl.op     = ffha_pkg::OP_LINK_BLK;
          state_next = S_F_LINK_PREV;
        end
      end
      S_F_EVAL: begin
        ctl.op     = ffha_pkg::OP_ADVANCE;
        state_next = S_F_CHECK;
      end
      S_F_LINK_PREV: begin
        ctl.op     = ffha_pkg::OP_LINK_PREV;
        state_next = S_F_READ_BLK;
      end
      S_F_READ_BLK: begin
        ctl.op     = ffha_pkg::OP_READ_BLK;
        state_next = S_F_NEXT_TEST;
      end
      S_F_NEXT_TEST: begin
        if (!stat.cur_nil && stat.next_adj) begin
          ctl.op     = ffha_pkg::OP_KEEP_BLK_READ_CUR;
          state_next = S_F_NEXT_MERGE;
        end else begin
          state_next = S_F_PREV_READ;
        end
      end
      S_F_NEXT_MERGE: begin
        ctl.op     = ffha_pkg::OP_MERGE_NEXT;
        state_next = S_F_PREV_READ;
      end
      S_F_PREV_READ: begin
        if (stat.prev_nil) begin
          res_code_next = ffha_pkg::ST_FREE_DONE;
          state_next    = S_DONE;
        end else begin
          ctl.op     = ffha_pkg::OP_READ_PREV;
          state_next = S_F_PREV_KEEP;
        end
      end
      S_F_PREV_KEEP: begin
        ctl.op     = ffha_pkg::OP_KEEP_PREV_READ_BLK;
        state_next = S_F_PREV_TEST;
      end
      S_F_PREV_TEST: begin
        if (stat.prev_adj) begin
          ctl.op = ffha_pkg::OP_MERGE_PREV;
        end
        res_code_next = ffha_pkg::ST_FREE_DONE;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      res_code  <= ffha_pkg::ST_FREE_DONE;
      cmd_stall <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_code  <= res_code_next;
      cmd_stall <= (state_next != S_IDLE);
      if (ctl.res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_stall == (state != S_IDLE))
    else $error("stall does not match idle state");

  a_accept_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid) |=> (state == S_ROUND && cmd_stall))
    else $error("accepted beat did not start a command");

  a_done_posts: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_take) |=> (res_valid && state == S_IDLE))
    else $error("result not posted on leaving done");

  a_code_known: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (res_code == ffha_pkg::ST_ALLOCATED ||
                           res_code == ffha_pkg::ST_NO_FIT ||
                           res_code == ffha_pkg::ST_FREE_DONE))
    else $error("done state without a result code");

endmodule

>>> rtl/ffha_datapath.sv
// header stores, walk pointers, size arithmetic and result register
module ffha_datapath #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 8,
  parameter int ALIGN_BYTES  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ffha_pkg::dp_ctl_t    ctl,
  input  ffha_pkg::cmd_item_t  cmd_item,
  output ffha_pkg::dp_stat_t   stat,
  output ffha_pkg::res_item_t  res_item
);

  function automatic int low_bit(input int v);
    int n;
    n = 0;
    for (int i = 4; i >= 0; i--) begin
      if (((v >> i) & 1) != 0) n = i;
    end
    return n;
  endfunction

  localparam int AW     = $clog2(HEAP_BYTES);
  localparam int SW     = $clog2(HEAP_BYTES + 1);
  localparam int PW     = ((AW > ffha_pkg::OFS_W) ? AW : ffha_pkg::OFS_W) + 1;
  localparam int SZW    = ffha_pkg::REQ_W + 1;
  localparam int AXW    = ((PW > SZW) ? PW : SZW) + 1;
  localparam int CW     = ((SW > SZW) ? SW : SZW) + 1;
  localparam int USHIFT = low_bit(ALIGN_BYTES | HEADER_BYTES);
  localparam int DEPTH  = (HEAP_BYTES + (1 << USHIFT) - 1) >> USHIFT;
  localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RSH    = 22;
  localparam int RCW    = RSH + 1;
  localparam int RECIP  = ((1 << RSH) + ALIGN_BYTES - 1) / ALIGN_BYTES;

  localparam logic [PW-1:0]  NIL     = {PW{1'b1}};
  localparam logic [PW-1:0]  HEAP_P  = PW'(HEAP_BYTES);
  localparam logic [SW-1:0]  HEAP_S  = SW'(HEAP_BYTES);
  localparam logic [SW-1:0]  INIT_SZ = SW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [RCW-1:0] RECIP_C = RCW'(RECIP);

  // header stores, indexed by block start in units of the common alignment
  logic [SW-1:0] size_mem [DEPTH];
  logic [PW-1:0] next_mem [DEPTH];

  ffha_pkg::cmd_item_t cmd_q;
  logic [SZW-1:0] quot, size_q;
  logic [PW-1:0]  cur, prev, blk, head;
  logic [SW-1:0]  steps;
  logic [SW-1:0]  mem_size_q, bsize, psize;
  logic [PW-1:0]  mem_next_q;
  logic           rd_inh;

  logic [SW-1:0]      eff_size;
  logic [PW-1:0]      eff_next;
  logic [SZW-1:0]     sum_req;
  logic [SZW+RCW-1:0] prod;
  logic [PW-1:0]      nb;
  logic [SW-1:0]      split_rem;

  logic          size_we, next_we, rd_en, head_we;
  logic          link_en;
  logic [PW-1:0] size_waddr, next_waddr, rd_addr, link_val;
  logic [SW-1:0] size_wdata;
  logic [PW-1:0] next_wdata, head_wdata;
  logic          size_wok, next_wok;

  // reads outside the heap see an empty block at the end of the list
  assign eff_size = rd_inh ? mem_size_q : '0;
  assign eff_next = rd_inh ? mem_next_q : NIL;

  assign sum_req   = SZW'(cmd_q.request_bytes) + SZW'(ALIGN_BYTES - 1);
  assign prod      = (SZW+RCW)'(sum_req) * (SZW+RCW)'(RECIP_C);
  assign nb        = PW'(AXW'(cur) + AXW'(HEADER_BYTES) + AXW'(size_q));
  assign split_rem = SW'(CW'(eff_size) - CW'(size_q) - CW'(HEADER_BYTES));

  assign stat.is_free       = (cmd_q.cmd == ffha_pkg::CMD_FREE);
  assign stat.skip_free     = cmd_q.pointer_null ||
                              (cmd_q.data_offset < ffha_pkg::OFS_W'(HEADER_BYTES));
  assign stat.cur_nil       = (cur == NIL);
  assign stat.prev_nil      = (prev == NIL);
  assign stat.steps_max     = (steps == HEAP_S);
  assign stat.cur_below_blk = (cur < blk);
  assign stat.fits          = (CW'(eff_size) >= CW'(size_q));
  assign stat.split         = (CW'(eff_size) > CW'(size_q) + CW'(HEADER_BYTES));
  assign stat.next_adj      = (AXW'(blk) + AXW'(HEADER_BYTES) + AXW'(eff_size)
                               == AXW'(cur));
  assign stat.prev_adj      = (AXW'(prev) + AXW'(HEADER_BYTES) + AXW'(psize)
                               == AXW'(blk));

  // memory port and list head commands
  always_comb begin
    size_we    = 1'b0;
    next_we    = 1'b0;
    rd_en      = 1'b0;
    link_en    = 1'b0;
    size_waddr = cur;
    next_waddr = cur;
    rd_addr    = cur;
    size_wdata = size_q[SW-1:0];
    next_wdata = NIL;
    link_val   = blk;
    unique case (ctl.op)
      ffha_pkg::OP_INIT: begin
        size_we    = 1'b1;
        next_we    = 1'b1;
        size_waddr = '0;
        next_waddr = '0;
        size_wdata = INIT_SZ;
        next_wdata = NIL;
      end
      ffha_pkg::OP_READ_CUR, ffha_pkg::OP_KEEP_BLK_READ_CUR: begin
        rd_en   = 1'b1;
        rd_addr = cur;
      end
      ffha_pkg::OP_SPLIT_TAIL: begin
        size_we    = 1'b1;
        next_we    = 1'b1;
        size_waddr = nb;
        next_waddr = nb;
        size_wdata = split_rem;
        next_wdata = eff_next;
      end
      ffha_pkg::OP_SPLIT_HEAD: begin
        size_we    = 1'b1;
        size_waddr = cur;
        size_wdata = SW'(size_q);
        link_en    = 1'b1;
        link_val   = nb;
      end
      ffha_pkg::OP_UNLINK: begin
        link_en  = 1'b1;
        link_val = eff_next;
      end
      ffha_pkg::OP_CLEAR_NEXT: begin
        next_we    = 1'b1;
        next_waddr = cur;
        next_wdata = NIL;
      end
      ffha_pkg::OP_LINK_BLK: begin
        next_we    = 1'b1;
        next_waddr = blk;
        next_wdata = cur;
      end
      ffha_pkg::OP_LINK_PREV: begin
        link_en  = 1'b1;
        link_val = blk;
      end
      ffha_pkg::OP_READ_BLK, ffha_pkg::OP_KEEP_PREV_READ_BLK: begin
        rd_en   = 1'b1;
        rd_addr = blk;
      end
      ffha_pkg::OP_MERGE_NEXT: begin
        size_we    = 1'b1;
        next_we    = 1'b1;
        size_waddr = blk;
        next_waddr = blk;
        size_wdata = SW'(CW'(bsize) + CW'(HEADER_BYTES) + CW'(eff_size));
        next_wdata = eff_next;
      end
      ffha_pkg::OP_READ_PREV: begin
        rd_en   = 1'b1;
        rd_addr = prev;
      end
      ffha_pkg::OP_MERGE_PREV: begin
        size_we    = 1'b1;
        next_we    = 1'b1;
        size_waddr = prev;
        next_waddr = prev;
        size_wdata = SW'(CW'(psize) + CW'(HEADER_BYTES) + CW'(eff_size));
        next_wdata = eff_next;
      end
      default: begin
      end
    endcase
    // a link from the list start goes to the head register
    head_we    = link_en && (prev == NIL);
    head_wdata = link_val;
    if (link_en && (prev != NIL)) begin
      next_we    = 1'b1;
      next_waddr = prev;
      next_wdata = link_val;
    end
  end

  assign size_wok = size_we && (size_waddr < HEAP_P);
  assign next_wok = next_we && (next_waddr < HEAP_P);

  always_ff @(posedge clk) begin
    if (size_wok) size_mem[size_waddr[USHIFT +: IW]] <= size_wdata;
    if (next_wok) next_mem[next_waddr[USHIFT +: IW]] <= next_wdata;
    if (rd_en) begin
      mem_size_q <= size_mem[rd_addr[USHIFT +: IW]];
      mem_next_q <= next_mem[rd_addr[USHIFT +: IW]];
      rd_inh     <= (rd_addr < HEAP_P);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (head_we) begin
      head <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      ffha_pkg::OP_LOAD: begin
        cmd_q <= cmd_item;
      end
      ffha_pkg::OP_ROUND: begin
        quot <= prod[RSH +: SZW];
      end
      ffha_pkg::OP_START: begin
        size_q <= SZW'(quot * SZW'(ALIGN_BYTES));
        cur    <= head;
        prev   <= NIL;
        steps  <= '0;
        blk    <= PW'(cmd_q.data_offset) - PW'(HEADER_BYTES);
      end
      ffha_pkg::OP_ADVANCE: begin
        prev  <= cur;
        cur   <= eff_next;
        steps <= steps + 1'b1;
      end
      ffha_pkg::OP_KEEP_BLK_READ_CUR: begin
        bsize <= eff_size;
      end
      ffha_pkg::OP_KEEP_PREV_READ_BLK: begin
        psize <= eff_size;
      end
      default: begin
      end
    endcase
    if (ctl.res_load) begin
      res_item.status <= ctl.res_status;
      if (ctl.res_status == ffha_pkg::ST_ALLOCATED) begin
        res_item.alloc_offset <= ffha_pkg::OFS_W'(cur + PW'(HEADER_BYTES));
      end else begin
        res_item.alloc_offset <= '0;
      end
    end
  end

endmodule

>>> rtl/first_fit_heap_allocator_unit.sv
// first-fit heap allocator: address-ordered free list with coalescing
// one command at a time; the walk reads one header at a time through the single read
// port of the stores
// reset: synchronous; after reset the init state writes the whole-heap header, stall held
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 8,
  parameter int ALIGN_BYTES  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ffha_pkg::cmd_item_t cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output ffha_pkg::res_item_t res_item
);

  ffha_pkg::dp_ctl_t  ctl;
  ffha_pkg::dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  ffha_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cmd_item (cmd_item),
    .stat     (stat),
    .res_item (res_item)
  );

endmodule

>>> test/first_fit_heap_allocator_unit_checker.sv
`timescale 1ns / 1ps
// scoreboard for the first-fit heap allocator: mirrors the free list and checks every reply
module first_fit_heap_allocator_unit_checker #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 8,
  parameter int ALIGN_BYTES  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_stall,
  input  ffha_pkg::cmd_item_t cmd_item,
  input  logic                res_valid,
  input  logic                res_stall,
  input  ffha_pkg::res_item_t res_item,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int unsigned NIL = 32'hFFFF_FFFF;

  // shadow heap, keyed by the byte address of a block header
  int unsigned free_list_head;
  int unsigned hdr_size [HEAP_BYTES];
  int unsigned hdr_link [HEAP_BYTES];

  ffha_pkg::res_item_t awaited_replies [$];
  ffha_pkg::res_item_t oldest;
  int                  error_total = 0;

  function automatic int unsigned size_at(input int unsigned a);
    return (a < HEAP_BYTES) ? hdr_size[a] : 0;
  endfunction

  function automatic int unsigned link_at(input int unsigned a);
    return (a < HEAP_BYTES) ? hdr_link[a] : NIL;
  endfunction

  // headers outside the heap swallow writes
  function automatic void put_size(input int unsigned a, input int unsigned v);
    if (a < HEAP_BYTES) hdr_size[a] = v;
  endfunction

  function automatic void put_link(input int unsigned a, input int unsigned v);
    if (a < HEAP_BYTES) hdr_link[a] = v;
  endfunction

  function automatic void point_after(input int unsigned prev, input int unsigned target);
    if (prev == NIL) free_list_head = target;
    else put_link(prev, target);
  endfunction

  function automatic ffha_pkg::res_item_t carve_block(input int unsigned req);
    int unsigned         want, cur, prev, steps, csz, cnext, tail, ofs;
    bit                  done;
    ffha_pkg::res_item_t r;
    want = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    r.status       = ffha_pkg::ST_NO_FIT;
    r.alloc_offset = '0;
    cur   = free_list_head;
    prev  = NIL;
    steps = 0;
    done  = 1'b0;
    while (!done && cur != NIL && steps < HEAP_BYTES) begin
      csz = size_at(cur);
      if (csz >= want) begin
        cnext = link_at(cur);
        if (csz > want + HEADER_BYTES) begin
          // split: the tail keeps the remainder and takes the list position
          tail = cur + HEADER_BYTES + want;
          put_size(tail, csz - want - HEADER_BYTES);
          put_link(tail, cnext);
          put_size(cur, want);
          point_after(prev, tail);
        end else begin
          point_after(prev, cnext);
        end
        put_link(cur, NIL);
        ofs            = cur + HEADER_BYTES;
        r.status       = ffha_pkg::ST_ALLOCATED;
        r.alloc_offset = ofs[ffha_pkg::OFS_W-1:0];
        done           = 1'b1;
      end else begin
        prev  = cur;
        cur   = link_at(cur);
        steps = steps + 1;
      end
    end
    return r;
  endfunction

  function automatic void return_block(input int unsigned data);
    int unsigned blk, cur, prev, steps;
    if (data >= HEADER_BYTES) begin
      blk   = data - HEADER_BYTES;
      cur   = free_list_head;
      prev  = NIL;
      steps = 0;
      while (cur != NIL && cur < blk && steps < HEAP_BYTES) begin
        prev  = cur;
        cur   = link_at(cur);
        steps = steps + 1;
      end
      put_link(blk, cur);
      point_after(prev, blk);
      if (cur != NIL && blk + HEADER_BYTES + size_at(blk) == cur) begin
        put_size(blk, size_at(blk) + HEADER_BYTES + size_at(cur));
        put_link(blk, link_at(cur));
      end
      if (prev != NIL && prev + HEADER_BYTES + size_at(prev) == blk) begin
        put_size(prev, size_at(prev) + HEADER_BYTES + size_at(blk));
        put_link(prev, link_at(blk));
      end
    end
  endfunction

  function automatic ffha_pkg::res_item_t heap_reply(input ffha_pkg::cmd_item_t it);
    ffha_pkg::res_item_t r;
    if (it.cmd == ffha_pkg::CMD_ALLOC) begin
      r = carve_block(32'(it.request_bytes));
    end else begin
      if (!it.pointer_null) return_block(32'(it.data_offset));
      r.status       = ffha_pkg::ST_FREE_DONE;
      r.alloc_offset = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < HEAP_BYTES; a++) begin
        hdr_size[a] = 0;
        hdr_link[a] = 0;
      end
      free_list_head = 0;
      hdr_size[0]    = HEAP_BYTES - HEADER_BYTES;
      hdr_link[0]    = NIL;
      awaited_replies.delete();
    end else begin
      // compare before queuing: a reply never belongs to the beat taken at the same edge
      if (res_valid && !res_stall) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected reply status %0d offset %0d", $time,
                   res_item.status, res_item.alloc_offset);
          error_total = error_total + 1;
        end else begin
          oldest = awaited_replies.pop_front();
          if (res_item.status !== oldest.status ||
              res_item.alloc_offset !== oldest.alloc_offset) begin
            $display("%0t: reply mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                     $time, oldest.status, oldest.alloc_offset,
                     res_item.status, res_item.alloc_offset);
            error_total = error_total + 1;
          end
        end
      end
      if (cmd_valid && !cmd_stall) awaited_replies.push_back(heap_reply(cmd_item));
    end
    outstanding <= awaited_replies.size();
    mismatches  <= error_total;
  end

endmodule

>>> test/first_fit_heap_allocator_unit_test.sv
`timescale 1ns / 1ps
// testbench top for the first-fit heap allocator: command traffic, stalls and verdict
module first_fit_heap_allocator_unit_test;

  localparam int HEAP_BYTES   = 16384;
  localparam int HEADER_BYTES = 8;
  localparam int ALIGN_BYTES  = 4;
  localparam int RANDOM_BEATS = 1000;
  localparam int CYCLE_LIMIT  = 3000000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  ffha_pkg::cmd_item_t cmd_item  = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  ffha_pkg::res_item_t res_item;

  logic idle_on     = 1'b1;
  int   stall_left  = 0;
  int   cycle_count = 0;
  int   mismatches;
  int   outstanding;
  int   n_granted   = 0;
  int   n_refused   = 0;
  int   n_freed     = 0;

  // data offsets handed out and not yet returned
  logic [ffha_pkg::OFS_W-1:0] live_ptrs [$];

  always #4 clk = ~clk;

  first_fit_heap_allocator_unit #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item (cmd_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

  first_fit_heap_allocator_unit_checker #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) heap_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls in random bursts while idle_on is set
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      res_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 19) - 1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      case (res_item.status)
        ffha_pkg::ST_ALLOCATED: begin
          n_granted <= n_granted + 1;
          live_ptrs.push_back(res_item.alloc_offset);
        end
        ffha_pkg::ST_NO_FIT: n_refused <= n_refused + 1;
        default:             n_freed <= n_freed + 1;
      endcase
    end
  end

  task automatic send_cmd(input ffha_pkg::cmd_item_t it);
    cmd_item  <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic issue_alloc(input int unsigned req);
    ffha_pkg::cmd_item_t it;
    it.cmd           = ffha_pkg::CMD_ALLOC;
    it.request_bytes = req[ffha_pkg::REQ_W-1:0];
    it.data_offset   = ffha_pkg::OFS_W'($urandom_range(0, 16383));
    it.pointer_null  = 1'($urandom_range(0, 1));
    send_cmd(it);
  endtask

  task automatic issue_free(input int unsigned ofs, input logic is_null);
    ffha_pkg::cmd_item_t it;
    it.cmd           = ffha_pkg::CMD_FREE;
    it.request_bytes = ffha_pkg::REQ_W'($urandom_range(0, 32767));
    it.data_offset   = ofs[ffha_pkg::OFS_W-1:0];
    it.pointer_null  = is_null;
    send_cmd(it);
  endtask

  task automatic free_some_live();
    int          idx;
    int unsigned ofs;
    idx = $urandom_range(0, live_ptrs.size() - 1);
    ofs = 32'(live_ptrs[idx]);
    live_ptrs.delete(idx);
    issue_free(ofs, 1'b0);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // carve a few small blocks, then return them to hit each merge case
    issue_alloc(0);
    issue_alloc(1);
    issue_alloc(3);
    issue_alloc(HEAP_BYTES);
    issue_alloc(100);
    wait_drained();
    issue_free(14'h3FFF, 1'b1);
    issue_free(HEADER_BYTES - 1, 1'b0);
    issue_free(0, 1'b0);
    issue_free(16, 1'b0);       // in front of the list head, no merge
    issue_free(40, 1'b0);       // merges with the next free block
    issue_free(28, 1'b0);       // merges on both sides
    issue_free(8, 1'b0);        // whole heap free again
    issue_alloc(HEAP_BYTES - HEADER_BYTES);
    issue_alloc(4);             // list empty
    issue_free(8, 1'b0);        // lands in an empty list
    issue_alloc(HEAP_BYTES - 2 * HEADER_BYTES);   // leftover is only a header: no split
    issue_free(8, 1'b0);
    issue_alloc(HEAP_BYTES - 2 * HEADER_BYTES - 4);
    issue_alloc(2);             // exact fit of the last tail
    issue_free(HEAP_BYTES - 4, 1'b0);
    issue_free(8, 1'b0);
    wait_drained();
    live_ptrs.delete();

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      idle_on <= (i < 450 || i >= 560) && i < RANDOM_BEATS - 150;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        case ($urandom_range(0, 2))
          0:       issue_free($urandom_range(0, 16383), 1'b1);
          1:       issue_free($urandom_range(0, HEADER_BYTES - 1), 1'b0);
          default: issue_alloc($urandom_range(HEAP_BYTES - HEADER_BYTES + 1, HEAP_BYTES));
        endcase
      end else if (r < 56 || live_ptrs.size() == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70)      issue_alloc($urandom_range(0, 256));
        else if (r < 94) issue_alloc($urandom_range(0, 2048));
        else             issue_alloc($urandom_range(0, HEAP_BYTES));
      end else begin
        free_some_live();
      end
      if (i % 250 == 249) wait_drained();
    end

    // hand everything back so the heap is one block again
    wait_drained();
    while (live_ptrs.size() != 0) free_some_live();
    wait_drained();

    // double free makes a self loop; the next walks run into the step bound
    issue_alloc(100);
    issue_alloc(100);
    issue_free(8, 1'b0);
    issue_free(8, 1'b0);
    issue_alloc(200);
    issue_free(116, 1'b0);
    issue_alloc(50);
    wait_drained();

    repeat (50) @(posedge clk);
    $display("covered %0d replies: %0d allocations granted, %0d refused, %0d frees done",
             n_granted + n_refused + n_freed, n_granted, n_refused, n_freed);
    $display("corner cases, random traffic with stalls on both sides, double free, bounded walks");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_datapath.sv
rtl/first_fit_heap_allocator_unit.sv
test/first_fit_heap_allocator_unit_checker.sv
test/first_fit_heap_allocator_unit_test.sv
